// ===== rtl/prt_pkg.sv =====
// Shared constants and types of the pointer registry table.
package prt_pkg;

    localparam int TYPE_W = 2;
    localparam int ADDR_W = 48;
    localparam int SIZE_W = 48;
    localparam int CNT_W  = 9;

    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_ADDR_BITS    = 48;
    localparam int DEF_HEADER_BYTES = 16;

    typedef enum logic [TYPE_W-1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_QUERY      = 2'd2
    } t_req_type;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_hull_upd;

endpackage

// ===== rtl/prt_req_if.sv =====
// Request channel: valid, ready and the request word.
interface prt_req_if import prt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] map_size;

    modport source (output valid, output req_type, output addr, output map_size, input ready);
    modport sink   (input valid, input req_type, input addr, input map_size, output ready);

endinterface

// ===== rtl/prt_rsp_if.sv =====
// Response channel: valid, ready and the response word.
interface prt_rsp_if import prt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SIZE_W-1:0] size_out;
    logic [CNT_W-1:0]  live_count;

    modport source (output valid, output hit, output size_out, output live_count, input ready);
    modport sink   (input valid, input hit, input size_out, input live_count, output ready);

endinterface

// ===== rtl/prt_slot_mem.sv =====
// Slot memory: one write port and one registered read port.
module prt_slot_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_idx,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_idx,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/prt_hull.sv =====
// Bounding hull of all registered mappings and the range check against it.
module prt_hull import prt_pkg::*; #(
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hull_upd         i_upd,
    input  logic [ADDR_W-1:0] i_probe,
    output logic              o_in_hull
);

    localparam int HW = ADDR_BITS;

    logic          r_pend;
    logic [HW-1:0] r_base;
    logic [HW-1:0] r_span;
    logic [HW-1:0] r_lo;
    logic [HW-1:0] r_hi;
    logic [HW-1:0] n_end;
    logic [HW-1:0] probe;

    // The base and span are registered with the update; the end and both compares use those registers.
    assign n_end = r_base + r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_lo   <= '1;
            r_hi   <= '0;
        end else begin
            r_pend <= i_upd.en;
            if (r_pend) begin
                if (r_base < r_lo) begin
                    r_lo <= r_base;
                end
                if (n_end > r_hi) begin
                    r_hi <= n_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            r_base <= HW'(i_upd.addr) - HW'(HEADER_BYTES);
            r_span <= HW'(i_upd.size);
        end
    end

    assign probe     = HW'(i_probe);
    assign o_in_hull = (probe >= r_lo) && (probe < r_hi);

endmodule

// ===== rtl/pointer_registry_table_unit.sv =====
// Pointer registry table: slot memory, sequential scan control and result register.
// Steps: an accepted request is registered, checked in S_CHECK, scanned in S_SCAN when needed
// and held in S_DONE until its response word is loaded into the response register.
// One request at a time: the next one is taken only once the response word has been loaded,
// so a stalled response word holds off the next request; the scan reads one slot per cycle.
// Reset is synchronous and active low; afterwards a clearing pass writes zero to every slot
// of the slot memory, and no request word is accepted until it completes.
module pointer_registry_table_unit import prt_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prt_req_if.sink    i_req,
    prt_rsp_if.source  o_rsp
);

    // Stored addresses keep only the bits that survive the address mask.
    localparam int SW  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int CXW = CW + CNT_W;
    localparam int MW  = SW + SIZE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CHECK = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cnt, n_cnt;
    t_req_type         r_type;
    logic [SW-1:0]     r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [SW-1:0]     r_key, n_key;
    logic              r_res_hit, n_res_hit;
    logic [SIZE_W-1:0] r_res_size, n_res_size;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [SIZE_W-1:0] r_out_size;
    logic [CNT_W-1:0]  r_out_cnt;

    logic              req_accept;
    logic              out_load;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic [MW-1:0]     wr_data;
    logic [IW-1:0]     rd_idx;
    logic [MW-1:0]     rd_data;
    logic [SW-1:0]     rd_slot_addr;
    logic [SIZE_W-1:0] rd_slot_size;
    logic              slot_match;
    logic              in_hull;
    t_hull_upd         hull_upd;
    logic [CXW-1:0]    cnt_ext;

    assign req_accept   = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // During a scan the read for the slot after the one being compared is already issued,
    // so every cycle compares one slot. An empty slot holds address zero, so a register
    // request scans for key zero and the other requests scan for their own address.
    assign rd_idx       = (r_state == S_CHECK) ? '0 : r_idx + IW'(1);
    assign rd_slot_addr = rd_data[MW-1:SIZE_W];
    assign rd_slot_size = rd_data[SIZE_W-1:0];
    assign slot_match   = (rd_slot_addr == r_key);

    prt_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (MW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    prt_hull #(
        .ADDR_BITS    (ADDR_BITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hull (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (hull_upd),
        .i_probe   (ADDR_W'(r_addr)),
        .o_in_hull (in_hull)
    );

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_key         = r_key;
        n_res_hit     = r_res_hit;
        n_res_size    = r_res_size;
        wr_en         = 1'b0;
        wr_idx        = r_idx;
        wr_data       = '0;
        hull_upd.en   = 1'b0;
        hull_upd.addr = ADDR_W'(r_addr);
        hull_upd.size = r_size;

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_IDLE: begin
                if (req_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // Address zero never matches, and a query outside the hull or on an
                // empty table misses without a scan.
                n_idx      = '0;
                n_res_hit  = 1'b0;
                n_res_size = '0;
                n_state    = S_DONE;
                case (r_type)
                    REQ_REGISTER: begin
                        n_key = '0;
                        if (r_addr != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    REQ_UNREGISTER: begin
                        n_key = r_addr;
                        if (r_addr != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    REQ_QUERY: begin
                        n_key = r_addr;
                        if ((r_addr != '0) && (r_cnt != '0) && in_hull) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_key = r_addr;
                    end
                endcase
            end
            S_SCAN: begin
                if (slot_match) begin
                    n_res_hit = 1'b1;
                    n_state   = S_DONE;
                    case (r_type)
                        REQ_REGISTER: begin
                            wr_en       = 1'b1;
                            wr_data     = {r_addr, r_size};
                            n_cnt       = r_cnt + CW'(1);
                            hull_upd.en = 1'b1;
                        end
                        REQ_UNREGISTER: begin
                            wr_en      = 1'b1;
                            n_res_size = rd_slot_size;
                            n_cnt      = r_cnt - CW'(1);
                        end
                        default: begin
                        end
                    endcase
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_res_hit  <= n_res_hit;
        r_res_size <= n_res_size;
        if (req_accept) begin
            r_type <= t_req_type'(i_req.req_type);
            r_addr <= i_req.addr[SW-1:0];
            r_size <= i_req.map_size;
        end
        if (out_load) begin
            r_out_hit  <= r_res_hit;
            r_out_size <= r_res_size;
            r_out_cnt  <= cnt_ext[CNT_W-1:0];
        end
    end

    // The reported count is the live count taken modulo 2**CNT_W, the range of the field.
    assign cnt_ext = CXW'(r_cnt);

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.size_out   = r_out_size;
    assign o_rsp.live_count = r_out_cnt;

endmodule

// ===== rtl/prt_checker.sv =====
// Port-level checks of the pointer registry table and their binding to the top level.
module prt_checker import prt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_hit,
    input logic [SIZE_W-1:0] i_out_size,
    input logic [CNT_W-1:0]  i_out_cnt
);

    logic [CNT_W-1:0] r_prev_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cnt <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_prev_cnt <= i_out_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_out_hit, i_out_size, i_out_cnt}))
        else $error("response word changed while stalled");

    a_size_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_size != '0) |-> i_out_hit)
        else $error("nonzero size reported on a miss");

    a_miss_keeps_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> (i_out_cnt == r_prev_cnt))
        else $error("live count changed on a miss");

    a_hit_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_hit |-> (i_out_cnt == r_prev_cnt) ||
            (i_out_cnt == r_prev_cnt + CNT_W'(1)) || (i_out_cnt == r_prev_cnt - CNT_W'(1)))
        else $error("live count moved by more than one");

endmodule

bind pointer_registry_table_unit prt_checker u_prt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_hit   (o_rsp.hit),
    .i_out_size  (o_rsp.size_out),
    .i_out_cnt   (o_rsp.live_count)
);

// ===== test/pointer_registry_table_unit_test.sv =====
// Self-checking testbench of the pointer registry table: directed table, then random traffic.
`timescale 1ns / 1ps

module pointer_registry_table_unit_test;
    import prt_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int TOTAL_WORDS = 550;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;

    localparam logic [TYPE_W-1:0] REQ_UNUSED   = 2'd3;
    localparam logic [ADDR_W-1:0] HEADER_BYTES = ADDR_W'(DEF_HEADER_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;
    localparam logic [SIZE_W-1:0] SIZE_ONES    = '1;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] map_size;
    } t_req_word;

    typedef struct packed {
        logic              hit;
        logic [SIZE_W-1:0] size_out;
        logic [CNT_W-1:0]  live_count;
    } t_rsp_word;

    // A directed row carries its answer only when pinned; the rest go to the predictor.
    typedef struct packed {
        t_req_word word;
        logic      pinned;
        t_rsp_word reply;
    } t_probe_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    prt_req_if req_if ();
    prt_rsp_if rsp_if ();

    pointer_registry_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the registry state.
    logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
    logic [SIZE_W-1:0] shadow_size [TABLE_DEPTH];
    int                shadow_live;
    logic [ADDR_W-1:0] hull_lo;
    logic [ADDR_W-1:0] hull_hi;

    t_rsp_word  pending_replies [$];
    t_probe_row probe_rows [$];

    int idle_pct = 15;
    int cycle_count = 0;
    int fault_count = 0;
    int words_sent = 0;
    int sent_by_type [4] = '{0, 0, 0, 0};
    int replies_seen = 0;
    int replies_hit = 0;
    int full_refusals = 0;

    // Index of the lowest slot holding the address, or TABLE_DEPTH when absent.
    function automatic int find_slot(input logic [ADDR_W-1:0] addr);
        int idx;
        idx = TABLE_DEPTH;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (shadow_addr[i] == addr) idx = i;
        end
        return idx;
    endfunction

    // Applies one request word to the shadow state and returns the answer it must produce.
    function automatic t_rsp_word registry_apply(input t_req_word w);
        t_rsp_word         r;
        int                slot;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] top;
        r = '0;
        case (w.req_type)
            REQ_REGISTER: begin
                if (w.addr != '0) begin
                    slot = find_slot('0);
                    if (slot < TABLE_DEPTH) begin
                        shadow_addr[slot] = w.addr;
                        shadow_size[slot] = w.map_size;
                        shadow_live++;
                        // Header offset and extent both wrap within the address width.
                        base = w.addr - HEADER_BYTES;
                        top  = base + w.map_size;
                        if (base < hull_lo) hull_lo = base;
                        if (top > hull_hi) hull_hi = top;
                        r.hit = 1'b1;
                    end else begin
                        full_refusals++;
                    end
                end
            end
            REQ_UNREGISTER: begin
                if (w.addr != '0) begin
                    slot = find_slot(w.addr);
                    if (slot < TABLE_DEPTH) begin
                        r.size_out = shadow_size[slot];
                        shadow_addr[slot] = '0;
                        shadow_size[slot] = '0;
                        if (shadow_live > 0) shadow_live--;
                        r.hit = 1'b1;
                    end
                end
            end
            REQ_QUERY: begin
                if (w.addr != '0 && shadow_live != 0 && w.addr >= hull_lo && w.addr < hull_hi
                        && find_slot(w.addr) < TABLE_DEPTH)
                    r.hit = 1'b1;
            end
            default: ;
        endcase
        r.live_count = shadow_live[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // Some live address when the table holds one, otherwise a random one.
    function automatic logic [ADDR_W-1:0] pick_live_addr();
        int                start;
        int                idx;
        logic              located;
        logic [ADDR_W-1:0] found;
        start   = $urandom_range(0, TABLE_DEPTH - 1);
        located = 1'b0;
        found   = rand_addr();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            idx = (start + i) % TABLE_DEPTH;
            if (!located && shadow_addr[idx] != '0) begin
                found   = shadow_addr[idx];
                located = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic logic [SIZE_W-1:0] draw_size();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return '0;
        if (roll == 1) return SIZE_ONES;
        if (roll < 4) return SIZE_W'($urandom_range(1, 4096));
        return rand_addr();
    endfunction

    // Register addresses: mostly fresh, some zero, some below the header size, some duplicates.
    function automatic logic [ADDR_W-1:0] draw_reg_addr();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return '0;
        if (roll == 1) return ADDR_W'($urandom_range(1, 15));
        if (roll < 4) return pick_live_addr();
        return rand_addr();
    endfunction

    function automatic t_req_word draw_request(input int reg_pct, input int unreg_pct);
        t_req_word w;
        int        roll;
        int        sel;
        roll       = $urandom_range(0, 99);
        sel        = $urandom_range(0, 9);
        w.map_size = draw_size();
        if (roll < reg_pct) begin
            w.req_type = REQ_REGISTER;
            w.addr     = draw_reg_addr();
        end else if (roll < reg_pct + unreg_pct) begin
            w.req_type = REQ_UNREGISTER;
            w.addr     = (sel < 2) ? ((sel == 0) ? '0 : rand_addr()) : pick_live_addr();
        end else if (roll < 95) begin
            w.req_type = REQ_QUERY;
            if (sel < 6)       w.addr = pick_live_addr();
            else if (sel == 6) w.addr = hull_lo;
            else if (sel == 7) w.addr = hull_hi;
            else if (sel == 8) w.addr = rand_addr();
            else               w.addr = '0;
        end else begin
            w.req_type = REQ_UNUSED;
            w.addr     = rand_addr();
        end
        return w;
    endfunction

    task automatic add_probe(input logic [TYPE_W-1:0] req_type, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] map_size, input logic pinned,
                             input logic hit, input logic [SIZE_W-1:0] size_out,
                             input logic [CNT_W-1:0] live_count);
        t_probe_row row;
        row.word   = '{req_type, addr, map_size};
        row.pinned = pinned;
        row.reply  = '{hit, size_out, live_count};
        probe_rows.push_back(row);
    endtask

    // Presents one request word after a random gap and books its answer once it is taken.
    task automatic issue_request(input t_req_word w, input logic pinned, input t_rsp_word typed);
        t_rsp_word predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= w.req_type;
        req_if.addr     <= w.addr;
        req_if.map_size <= w.map_size;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = registry_apply(w);
        pending_replies.push_back(pinned ? typed : predicted);
        words_sent++;
        sent_by_type[w.req_type]++;
    endtask

    // Withdraws the last request word so it is not taken twice, then waits for every answer.
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic void note_fault(input string what, input t_rsp_word want,
                                       input t_rsp_word got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] %s: expected hit %0b size %h count %0d, got hit %0b size %h count %0d",
                     $realtime, what, want.hit, want.size_out, want.live_count,
                     got.hit, got.size_out, got.live_count);
    endfunction

    // The response side stalls at random, at the same rate as the request side idles.
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_rsp_word got;
        t_rsp_word want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.hit, rsp_if.size_out, rsp_if.live_count};
            replies_seen++;
            if (got.hit) replies_hit++;
            if (pending_replies.size() == 0) begin
                note_fault("answer with nothing outstanding", '0, got);
            end else begin
                want = pending_replies.pop_front();
                if (got.hit !== want.hit)               note_fault("hit differs", want, got);
                else if (got.size_out !== want.size_out) note_fault("size differs", want, got);
                else if (got.live_count !== want.live_count)
                    note_fault("live count differs", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d answers outstanding",
                     cycle_count, pending_replies.size());
            $display("pointer_registry_table_unit_test failed");
            $finish;
        end
    end

    initial begin
        t_req_word w;
        int        n;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_REGISTER;
        req_if.addr     = '0;
        req_if.map_size = '0;
        rsp_if.ready    = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_addr[i] = '0;
            shadow_size[i] = '0;
        end
        shadow_live = 0;
        hull_lo     = ADDR_MAX;
        hull_hi     = '0;

        // Directed table. Columns: type, address, size, pinned, hit, size out, live count.
        // Empty-table misses, then the address-zero cases and the unused type.
        add_probe(REQ_QUERY,      48'h1,    48'h0,     1'b1, 1'b0, 48'h0,     9'd0);
        add_probe(REQ_UNREGISTER, 48'h1000, 48'h0,     1'b1, 1'b0, 48'h0,     9'd0);
        add_probe(REQ_REGISTER,   48'h0,    48'h5,     1'b1, 1'b0, 48'h0,     9'd0);
        add_probe(REQ_UNUSED,     ADDR_MAX, SIZE_ONES, 1'b1, 1'b0, 48'h0,     9'd0);
        // Largest address and size: the hull end wraps around.
        add_probe(REQ_REGISTER,   ADDR_MAX, SIZE_ONES, 1'b1, 1'b1, 48'h0,     9'd1);
        add_probe(REQ_QUERY,      ADDR_MAX, 48'h0,     1'b0, 1'b0, 48'h0,     9'd0);
        // An address below the header size wraps the hull base; this entry has zero size.
        add_probe(REQ_REGISTER,   48'h1,    48'h0,     1'b1, 1'b1, 48'h0,     9'd2);
        add_probe(REQ_REGISTER,   48'h10,   48'h100,   1'b1, 1'b1, 48'h0,     9'd3);
        add_probe(REQ_QUERY,      48'h10,   48'h0,     1'b0, 1'b0, 48'h0,     9'd0);
        add_probe(REQ_QUERY,      48'h20,   48'h0,     1'b0, 1'b0, 48'h0,     9'd0);
        // A duplicate registration; removal takes the lower slot first.
        add_probe(REQ_REGISTER,   48'h10,   48'h200,   1'b1, 1'b1, 48'h0,     9'd4);
        add_probe(REQ_UNREGISTER, 48'h10,   48'h0,     1'b1, 1'b1, 48'h100,   9'd3);
        add_probe(REQ_QUERY,      48'h10,   48'h0,     1'b0, 1'b0, 48'h0,     9'd0);
        add_probe(REQ_UNREGISTER, 48'h10,   48'h0,     1'b1, 1'b1, 48'h200,   9'd2);
        add_probe(REQ_UNREGISTER, 48'h10,   48'h0,     1'b1, 1'b0, 48'h0,     9'd2);
        add_probe(REQ_UNREGISTER, 48'h1,    48'h0,     1'b1, 1'b1, 48'h0,     9'd1);
        add_probe(REQ_REGISTER,   48'h20,   48'h40,    1'b1, 1'b1, 48'h0,     9'd2);
        add_probe(REQ_QUERY,      48'h0,    48'h0,     1'b1, 1'b0, 48'h0,     9'd2);
        add_probe(REQ_UNREGISTER, 48'h0,    48'h0,     1'b1, 1'b0, 48'h0,     9'd2);
        add_probe(REQ_UNUSED,     48'h20,   48'h0,     1'b1, 1'b0, 48'h0,     9'd2);
        add_probe(REQ_UNREGISTER, ADDR_MAX, 48'h0,     1'b1, 1'b1, SIZE_ONES, 9'd1);
        add_probe(REQ_UNREGISTER, 48'h20,   48'h0,     1'b1, 1'b1, 48'h40,    9'd0);
        // Hull stays wide, but an empty table never hits.
        add_probe(REQ_QUERY,      48'h20,   48'h0,     1'b1, 1'b0, 48'h0,     9'd0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[i])
            issue_request(probe_rows[i].word, probe_rows[i].pinned, probe_rows[i].reply);

        // Mixed traffic, with a stretch where neither side idles.
        for (int i = 0; i < 120; i++) begin
            idle_pct = (i >= 40 && i < 80) ? 0 : 15;
            issue_request(draw_request(40, 25), 1'b0, '0);
        end

        // Let the block drain completely before the next burst.
        wait_drained();

        // Fill the table to the last slot, then knock on it while full.
        while (shadow_live < TABLE_DEPTH) begin
            w = '{REQ_REGISTER, draw_reg_addr(), draw_size()};
            issue_request(w, 1'b0, '0);
        end
        for (int i = 0; i < 4; i++) begin
            w = '{REQ_REGISTER, rand_addr(), draw_size()};
            issue_request(w, 1'b0, '0);
        end
        for (int i = 0; i < 6; i++) begin
            w = '{REQ_QUERY, pick_live_addr(), '0};
            issue_request(w, 1'b0, '0);
        end

        // Removal-heavy traffic for the rest of the run.
        n = 0;
        while (words_sent < TOTAL_WORDS || n < 100) begin
            issue_request(draw_request(25, 50), 1'b0, '0);
            n++;
        end

        idle_pct = 0;
        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        $display("Sent %0d words: %0d register, %0d unregister, %0d query, %0d unused type.",
                 words_sent, sent_by_type[REQ_REGISTER], sent_by_type[REQ_UNREGISTER],
                 sent_by_type[REQ_QUERY], sent_by_type[REQ_UNUSED]);
        $display("Checked %0d answers (%0d hits); %0d registrations refused on a full table.",
                 replies_seen, replies_hit, full_refusals);
        if (fault_count == 0 && pending_replies.size() == 0) begin
            $display("pointer_registry_table_unit_test passed");
        end else begin
            $display("%0d faults, %0d answers never arrived", fault_count,
                     pending_replies.size());
            $display("pointer_registry_table_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/prt_pkg.sv
rtl/prt_req_if.sv
rtl/prt_rsp_if.sv
rtl/prt_slot_mem.sv
rtl/prt_hull.sv
rtl/pointer_registry_table_unit.sv
rtl/prt_checker.sv
test/pointer_registry_table_unit_test.sv
